/* hw/rtl/mrcs_pkg.sv */
// Shared types, codes and helpers for the motion rep counter and scorer.
`default_nettype none

package mrcs_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_REPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_ANGLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_GYRO   = 3'd4;

    // defaults used when a register holds zero or less
    localparam logic        [7:0]  DEF_REPS   = 8'd5;
    localparam logic signed [15:0] DEF_ENTER  = 16'sd1500;
    localparam logic signed [15:0] DEF_EXIT   = 16'sd800;
    localparam logic signed [15:0] DEF_TARGET = 16'sd6000;
    localparam logic signed [15:0] DEF_GYRO   = 16'sd200;

    localparam logic [6:0] SCORE_MAX = 7'd100;

    // shared divider geometry
    localparam int unsigned DIV_W     = 24;
    localparam int unsigned DVS_W     = 16;
    localparam int unsigned DIV_CNT_W = 5;

    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

    // x * 100 as shifts and adds
    function automatic logic [DIV_W-1:0] mul100(input logic [21:0] x);
        logic [DIV_W-1:0] w;
        w = {2'b00, x};
        return (w << 6) + (w << 5) + (w << 2);
    endfunction

    function automatic logic [6:0] clamp_score(input logic [DIV_W-1:0] q);
        return (q > DIV_W'(100)) ? SCORE_MAX : q[6:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mrcs_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all score and mean ratios.
`default_nettype none

module mrcs_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mrcs_pkg::t_div_req             i_req,
    input  logic [mrcs_pkg::DIV_W-1:0]     i_dividend,
    input  logic [mrcs_pkg::DVS_W-1:0]     i_divisor,
    output mrcs_pkg::t_div_rsp             o_rsp,
    output logic [mrcs_pkg::DIV_W-1:0]     o_quotient
);
    import mrcs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0]       w_shift;
    logic [DVS_W:0]       w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* hw/rtl/motion_rep_counter_scorer_top.sv */
// Top level: rep detection state, config latch, sequencer and scoring around a shared divider.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+------------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_operation, i_sample_valid, i_upper_arm_stable,
//          |            |             | i_rotation_angle, i_roll_gyro_rate
//  out     | o_out_valid| i_out_ready | o_shown_angle .. o_done_res
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Each request passes through an update state, then three 24-step divisions (mean peak,
//  completion, amplitude) on the one shared divider, before it is published.
//  Input is taken only while the sequencer is idle; a finished result waits in the output
//  register, and the next request is accepted meanwhile but publishes only once it is taken.
//  Reset is synchronous, active low; config registers reset to their default values.
//  Config writes are always accepted.
`default_nettype none

module motion_rep_counter_scorer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic                              i_sample_valid,
    input  logic                              i_upper_arm_stable,
    input  logic signed [15:0]                i_rotation_angle,
    input  logic signed [15:0]                i_roll_gyro_rate,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [15:0]                o_shown_angle,
    output logic                              o_mid_rep,
    output logic [7:0]                        o_rep_count,
    output logic [14:0]                       o_max_peak,
    output logic [14:0]                       o_average_peak,
    output logic [6:0]                        o_reps_score,
    output logic [6:0]                        o_reach_score,
    output logic [6:0]                        o_blend_score,
    output logic                              o_rep_completed,
    output logic                              o_goal_hit,
    output logic                              o_running,
    output logic                              o_done_res,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mrcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import mrcs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_UPDATE   = 6'b000010,
        S_DIV_MEAN = 6'b000100,
        S_DIV_COMP = 6'b001000,
        S_DIV_AMP  = 6'b010000,
        S_PUBLISH  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_div_go, n_div_go;

    // raw config registers
    logic        [7:0]  r_reg_reps;
    logic signed [15:0] r_reg_enter, r_reg_exit, r_reg_target, r_reg_gyro;

    // latched, sanitized config
    logic        [7:0]  r_cfg_reps, n_cfg_reps;
    logic signed [15:0] r_cfg_enter, n_cfg_enter;
    logic signed [15:0] r_cfg_exit, n_cfg_exit;
    logic signed [15:0] r_cfg_target, n_cfg_target;
    logic signed [15:0] r_cfg_gyro, n_cfg_gyro;

    // captured request
    logic [1:0]         r_op;
    logic               r_svalid, r_stable;
    logic signed [15:0] r_angle, r_rate;

    // tracking state
    logic               r_run, n_run;
    logic               r_done, n_done;
    logic               r_motion, n_motion;
    logic [7:0]         r_reps, n_reps;
    logic signed [15:0] r_last, n_last;
    logic signed [15:0] r_peak, n_peak;
    logic [14:0]        r_best, n_best;
    logic [23:0]        r_total, n_total;
    logic [15:0]        r_mean;
    logic               r_rep_pulse, n_rep_pulse;
    logic               r_fin_pulse, n_fin_pulse;
    logic [6:0]         r_comp, r_amp;

    // sanitizing and sample helpers
    logic        [7:0]  w_san_reps;
    logic signed [15:0] w_san_enter, w_exit_pos, w_san_exit, w_san_target, w_san_gyro;
    logic [16:0]        w_rate_x, w_mag;
    logic signed [15:0] w_peak_up;
    logic [7:0]         w_reps_inc;
    logic [7:0]         w_score_sum;

    // divider hookup
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic [DIV_W-1:0]   w_dividend;
    logic [DVS_W-1:0]   w_divisor;
    logic [DIV_W-1:0]   w_quotient;

    logic               w_in_take;
    logic               w_publish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_publish   = (r_state == S_PUBLISH) && (!o_out_valid || i_out_ready);

    assign w_san_reps   = (r_reg_reps == 8'd0) ? DEF_REPS : r_reg_reps;
    assign w_san_enter  = (r_reg_enter <= 16'sd0) ? DEF_ENTER : r_reg_enter;
    assign w_exit_pos   = (r_reg_exit <= 16'sd0) ? DEF_EXIT : r_reg_exit;
    assign w_san_exit   = (w_exit_pos > w_san_enter) ? (w_san_enter >>> 1) : w_exit_pos;
    assign w_san_target = (r_reg_target <= 16'sd0) ? DEF_TARGET : r_reg_target;
    assign w_san_gyro   = (r_reg_gyro <= 16'sd0) ? DEF_GYRO : r_reg_gyro;

    assign w_rate_x   = {r_rate[15], r_rate};
    assign w_mag      = r_rate[15] ? (~w_rate_x + 17'd1) : w_rate_x;
    assign w_peak_up  = (r_angle > r_peak) ? r_angle : r_peak;
    assign w_reps_inc = r_reps + 8'd1;

    // per-request state update
    always_comb begin
        n_run        = r_run;
        n_done       = r_done;
        n_motion     = r_motion;
        n_reps       = r_reps;
        n_last       = r_last;
        n_peak       = r_peak;
        n_best       = r_best;
        n_total      = r_total;
        n_rep_pulse  = r_rep_pulse;
        n_fin_pulse  = r_fin_pulse;
        n_cfg_reps   = r_cfg_reps;
        n_cfg_enter  = r_cfg_enter;
        n_cfg_exit   = r_cfg_exit;
        n_cfg_target = r_cfg_target;
        n_cfg_gyro   = r_cfg_gyro;
        unique case (r_op)
            OP_SAMPLE: begin
                n_rep_pulse = 1'b0;
                n_fin_pulse = 1'b0;
                if (r_run && !r_done) begin
                    if (!r_svalid || !r_stable) begin
                        n_last   = r_svalid ? r_angle : 16'sd0;
                        n_motion = 1'b0;
                        n_peak   = 16'sd0;
                    end else begin
                        n_last = r_angle;
                        if (!r_motion) begin
                            if (r_angle >= r_cfg_enter || w_mag >= {1'b0, r_cfg_gyro}) begin
                                n_motion = 1'b1;
                                n_peak   = r_angle;
                            end
                        end else begin
                            n_peak = w_peak_up;
                            // rep ends: back under exit level after peaking past enter
                            if (r_angle <= r_cfg_exit && w_peak_up >= r_cfg_enter) begin
                                n_motion    = 1'b0;
                                n_reps      = w_reps_inc;
                                n_rep_pulse = 1'b1;
                                if (w_peak_up[14:0] > r_best) begin
                                    n_best = w_peak_up[14:0];
                                end
                                n_total = r_total + {9'd0, w_peak_up[14:0]};
                                if (w_reps_inc >= r_cfg_reps) begin
                                    n_done      = 1'b1;
                                    n_run       = 1'b0;
                                    n_fin_pulse = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            OP_START: begin
                n_cfg_reps   = w_san_reps;
                n_cfg_enter  = w_san_enter;
                n_cfg_exit   = w_san_exit;
                n_cfg_target = w_san_target;
                n_cfg_gyro   = w_san_gyro;
                n_run        = 1'b1;
                n_done       = 1'b0;
                n_motion     = 1'b0;
                n_reps       = 8'd0;
                n_last       = 16'sd0;
                n_peak       = 16'sd0;
                n_best       = 15'd0;
                n_total      = 24'd0;
                n_rep_pulse  = 1'b0;
                n_fin_pulse  = 1'b0;
            end
            OP_STOP: begin
                n_run    = 1'b0;
                n_motion = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state  = S_DIV_MEAN;
                n_div_go = 1'b1;
            end
            S_DIV_MEAN: begin
                if (w_div_rsp.done) begin
                    n_state  = S_DIV_COMP;
                    n_div_go = 1'b1;
                end
            end
            S_DIV_COMP: begin
                if (w_div_rsp.done) begin
                    n_state  = S_DIV_AMP;
                    n_div_go = 1'b1;
                end
            end
            S_DIV_AMP: begin
                if (w_div_rsp.done) n_state = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (w_publish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operand select for the shared divider
    always_comb begin
        unique case (r_state)
            S_DIV_COMP: begin
                w_dividend = mul100({14'd0, r_reps});
                w_divisor  = {8'd0, r_cfg_reps};
            end
            S_DIV_AMP: begin
                w_dividend = mul100({7'd0, r_best});
                w_divisor  = r_cfg_target;
            end
            default: begin
                w_dividend = r_total;
                w_divisor  = {8'd0, r_reps};
            end
        endcase
    end

    assign w_div_req.start = r_div_go;

    mrcs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_rsp      (w_div_rsp),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_div_go     <= 1'b0;
            r_reg_reps   <= DEF_REPS;
            r_reg_enter  <= DEF_ENTER;
            r_reg_exit   <= DEF_EXIT;
            r_reg_target <= DEF_TARGET;
            r_reg_gyro   <= DEF_GYRO;
            r_cfg_reps   <= DEF_REPS;
            r_cfg_enter  <= DEF_ENTER;
            r_cfg_exit   <= DEF_EXIT;
            r_cfg_target <= DEF_TARGET;
            r_cfg_gyro   <= DEF_GYRO;
            r_run        <= 1'b0;
            r_done       <= 1'b0;
            r_motion     <= 1'b0;
            r_reps       <= 8'd0;
            r_last       <= 16'sd0;
            r_peak       <= 16'sd0;
            r_best       <= 15'd0;
            r_total      <= 24'd0;
            r_mean       <= 16'd0;
            r_rep_pulse  <= 1'b0;
            r_fin_pulse  <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TARGET_REPS:  r_reg_reps   <= i_cfg_data[7:0];
                    REG_ENTER_ANGLE:  r_reg_enter  <= i_cfg_data;
                    REG_EXIT_ANGLE:   r_reg_exit   <= i_cfg_data;
                    REG_TARGET_ANGLE: r_reg_target <= i_cfg_data;
                    REG_ENTER_GYRO:   r_reg_gyro   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_UPDATE) begin
                r_cfg_reps   <= n_cfg_reps;
                r_cfg_enter  <= n_cfg_enter;
                r_cfg_exit   <= n_cfg_exit;
                r_cfg_target <= n_cfg_target;
                r_cfg_gyro   <= n_cfg_gyro;
                r_run        <= n_run;
                r_done       <= n_done;
                r_motion     <= n_motion;
                r_reps       <= n_reps;
                r_last       <= n_last;
                r_peak       <= n_peak;
                r_best       <= n_best;
                r_total      <= n_total;
                r_rep_pulse  <= n_rep_pulse;
                r_fin_pulse  <= n_fin_pulse;
            end

            // no reps means mean of zero; the divider result is meaningless then
            if (r_state == S_DIV_MEAN && w_div_rsp.done) begin
                r_mean <= (r_reps == 8'd0) ? 16'd0 : w_quotient[15:0];
            end

            if (w_publish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // request capture, score capture and output payload
    assign w_score_sum = {1'b0, r_comp} + {1'b0, r_amp};

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op     <= i_operation;
            r_svalid <= i_sample_valid;
            r_stable <= i_upper_arm_stable;
            r_angle  <= i_rotation_angle;
            r_rate   <= i_roll_gyro_rate;
        end
        if (r_state == S_DIV_COMP && w_div_rsp.done) r_comp <= clamp_score(w_quotient);
        if (r_state == S_DIV_AMP && w_div_rsp.done)  r_amp  <= clamp_score(w_quotient);
        if (w_publish) begin
            o_shown_angle   <= r_last;
            o_mid_rep       <= r_motion;
            o_rep_count     <= r_reps;
            o_max_peak      <= r_best;
            o_average_peak  <= r_mean[14:0];
            o_reps_score    <= r_comp;
            o_reach_score   <= r_amp;
            o_blend_score   <= w_score_sum[7:1];
            o_rep_completed <= r_rep_pulse;
            o_goal_hit      <= r_fin_pulse;
            o_running       <= r_run;
            o_done_res      <= r_done;
        end
    end

    a_done_stops_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("done flag set while still running");

    a_reps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reps <= r_cfg_reps)
        else $error("rep count passed the target");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

    a_out_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_PUBLISH))
        else $error("result raised outside publish");

endmodule

`default_nettype wire
